[src/ogcm_pkg.sv]
`timescale 1ns / 1ps
package ogcm_pkg;

    // fixed field widths
    localparam int OP_W        = 3;
    localparam int COORD_IN_W  = 9;
    localparam int SIDE_IN_W   = 7;
    localparam int OWNER_IN_W  = 8;
    localparam int GRID_W_W    = 8;
    localparam int GRID_H_W    = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    // parameter defaults
    localparam int DEF_MAX_COLUMNS   = 128;
    localparam int DEF_MAX_ROWS      = 64;
    localparam int DEF_MAX_RECT_SIDE = 64;
    localparam int DEF_OWNER_BITS    = 8;

    localparam logic [GRID_W_W-1:0] GRID_WIDTH_RST  = 8'd128;
    localparam logic [GRID_H_W-1:0] GRID_HEIGHT_RST = 7'd64;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_CLEAR = 3'd0;
    localparam op_t OP_STAMP = 3'd1;
    localparam op_t OP_ERASE = 3'd2;
    localparam op_t OP_CHECK = 3'd3;
    localparam op_t OP_MOVE  = 3'd4;

    localparam cfg_idx_t CFG_GRID_WIDTH  = 1'd0;
    localparam cfg_idx_t CFG_GRID_HEIGHT = 1'd1;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // capture request word
        logic lin_clear;  // restart linear sweep
        logic clr_go;     // write free at sweep address, advance
        logic ers_go;     // read at sweep address for erase, advance
        logic rect_init;  // load rectangle walkers
        logic rect_go;    // visit current rectangle cell, advance
        logic post;       // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic lin_last;
        logic rect_last;
        logic rect_empty;
        logic res_free;
    } sts_t;

endpackage

[src/ogcm_if.sv]
`timescale 1ns / 1ps
interface ogcm_req_if;
    import ogcm_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [OP_W-1:0]                operation;
    logic signed [COORD_IN_W-1:0]   x_origin;
    logic signed [COORD_IN_W-1:0]   y_origin;
    logic [SIDE_IN_W-1:0]           rect_width;
    logic [SIDE_IN_W-1:0]           rect_height;
    logic [OWNER_IN_W-1:0]          owner_id;

    modport source (
        output valid, operation, x_origin, y_origin, rect_width, rect_height, owner_id,
        input  ready
    );
    modport sink (
        input  valid, operation, x_origin, y_origin, rect_width, rect_height, owner_id,
        output ready
    );
endinterface

interface ogcm_rsp_if;
    import ogcm_pkg::*;

    logic            valid;
    logic            ready;
    logic            blocked;
    logic [OP_W-1:0] done_operation;

    modport source (
        output valid, blocked, done_operation,
        input  ready
    );
    modport sink (
        input  valid, blocked, done_operation,
        output ready
    );
endinterface

[src/ogcm_ctrl.sv]
`timescale 1ns / 1ps
module ogcm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ogcm_pkg::sts_t sts,
    output ogcm_pkg::cmd_t cmd
);
    import ogcm_pkg::*;

    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_SETUP  = 9'b000000100,
        ST_CLEAR  = 9'b000001000,
        ST_ERASE  = 9'b000010000,
        ST_EDRAIN = 9'b000100000,
        ST_RECT   = 9'b001000000,
        ST_DRAIN  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                // clearing pass after reset
                cmd.clr_go = 1'b1;
                if (sts.lin_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.lin_clear = 1'b1;
                cmd.rect_init = 1'b1;
                case (sts.op) inside
                    OP_CLEAR:           state_next = ST_CLEAR;
                    OP_ERASE, OP_MOVE:  state_next = ST_ERASE;
                    OP_STAMP, OP_CHECK: state_next = sts.rect_empty ? ST_DONE : ST_RECT;
                    default:            state_next = ST_DONE;
                endcase
            end
            ST_CLEAR:
            begin
                cmd.clr_go = 1'b1;
                if (sts.lin_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ERASE:
            begin
                cmd.ers_go = 1'b1;
                if (sts.lin_last)
                begin
                    state_next = ST_EDRAIN;
                end
            end
            ST_EDRAIN:
            begin
                // last erase write lands here
                if (sts.op == OP_MOVE && !sts.rect_empty)
                begin
                    state_next = ST_RECT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RECT:
            begin
                cmd.rect_go = 1'b1;
                if (sts.rect_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.res_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

[src/ogcm_dp.sv]
`timescale 1ns / 1ps
module ogcm_dp #(
    parameter int MAX_COLUMNS   = ogcm_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = ogcm_pkg::DEF_MAX_ROWS,
    parameter int MAX_RECT_SIDE = ogcm_pkg::DEF_MAX_RECT_SIDE,
    parameter int OWNER_BITS    = ogcm_pkg::DEF_OWNER_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_we,
    input  logic [ogcm_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [ogcm_pkg::CFG_DATA_W-1:0]           cfg_data,
    // request word
    input  logic [ogcm_pkg::OP_W-1:0]                 req_operation,
    input  logic signed [ogcm_pkg::COORD_IN_W-1:0]    req_x_origin,
    input  logic signed [ogcm_pkg::COORD_IN_W-1:0]    req_y_origin,
    input  logic [ogcm_pkg::SIDE_IN_W-1:0]            req_rect_width,
    input  logic [ogcm_pkg::SIDE_IN_W-1:0]            req_rect_height,
    input  logic [ogcm_pkg::OWNER_IN_W-1:0]           req_owner_id,
    // response word
    output logic                                      rsp_valid,
    input  logic                                      rsp_ready,
    output logic                                      rsp_blocked,
    output logic [ogcm_pkg::OP_W-1:0]                 rsp_done_operation,
    // control
    input  ogcm_pkg::cmd_t                            cmd,
    output ogcm_pkg::sts_t                            sts
);
    import ogcm_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int SIDE_W  = $clog2(MAX_RECT_SIDE + 1);
    localparam int CW_A    = (COL_W + 1 > ROW_W + 1) ? COL_W + 1 : ROW_W + 1;
    localparam int CW_B    = (SIDE_W + 2 > COORD_IN_W + 1) ? SIDE_W + 2 : COORD_IN_W + 1;
    localparam int COORD_W = (CW_A > CW_B) ? CW_A : CW_B;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_IN_W-1:0] v);
        logic [SIDE_W-1:0] s;
        if (int'(v) > MAX_RECT_SIDE)
        begin
            s = SIDE_W'(MAX_RECT_SIDE);
        end
        else
        begin
            s = SIDE_W'(v);
        end
        return s;
    endfunction

    // configuration registers
    logic [GRID_W_W-1:0] gw_reg;
    logic [GRID_H_W-1:0] gh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= GRID_WIDTH_RST;
            gh_reg <= GRID_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  gw_reg <= cfg_data[GRID_W_W-1:0];
                CFG_GRID_HEIGHT: gh_reg <= cfg_data[GRID_H_W-1:0];
                default:         gw_reg <= gw_reg;
            endcase
        end
    end

    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;

    assign cols = (int'(gw_reg) > MAX_COLUMNS) ? COL_W'(MAX_COLUMNS) : COL_W'(gw_reg);
    assign rows = (int'(gh_reg) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(gh_reg);

    // captured request
    op_t                          op_reg;
    logic signed [COORD_IN_W-1:0] x0_reg;
    logic signed [COORD_IN_W-1:0] y0_reg;
    logic [SIDE_W-1:0]            w_reg;
    logic [SIDE_W-1:0]            h_reg;
    logic [OWNER_BITS-1:0]        owner_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= req_operation;
            x0_reg    <= req_x_origin;
            y0_reg    <= req_y_origin;
            w_reg     <= clamp_side(req_rect_width);
            h_reg     <= clamp_side(req_rect_height);
            owner_reg <= OWNER_BITS'(req_owner_id);
        end
    end

    // linear sweep over the whole store
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic              lin_last;

    assign lin_last = (lin_reg == ADDR_W'(DEPTH - 1));

    always_comb
    begin
        lin_next = lin_reg;
        if (cmd.lin_clear)
        begin
            lin_next = '0;
        end
        else if (cmd.clr_go || cmd.ers_go)
        begin
            lin_next = lin_last ? '0 : lin_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg <= '0;
        end
        else
        begin
            lin_reg <= lin_next;
        end
    end

    // rectangle walk, row by row
    logic [SIDE_W-1:0]         j_reg, i_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic                      row_end, rect_last, rect_empty;

    assign row_end    = (j_reg == w_reg - 1'b1);
    assign rect_last  = row_end && (i_reg == h_reg - 1'b1);
    assign rect_empty = (w_reg == '0) || (h_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.rect_init)
        begin
            j_reg <= '0;
            i_reg <= '0;
            x_reg <= COORD_W'(x0_reg);
            y_reg <= COORD_W'(y0_reg);
        end
        else if (cmd.rect_go)
        begin
            if (row_end)
            begin
                j_reg <= '0;
                x_reg <= COORD_W'(x0_reg);
                i_reg <= i_reg + 1'b1;
                y_reg <= y_reg + COORD_W'(1);
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
                x_reg <= x_reg + COORD_W'(1);
            end
        end
    end

    logic              in_grid;
    logic [ADDR_W-1:0] rect_addr;

    assign in_grid = !x_reg[COORD_W-1] && ($unsigned(x_reg) < COORD_W'(cols))
                  && !y_reg[COORD_W-1] && ($unsigned(y_reg) < COORD_W'(rows));
    assign rect_addr = ADDR_W'(ADDR_W'($unsigned(y_reg)) * ADDR_W'(MAX_COLUMNS)
                     + ADDR_W'($unsigned(x_reg)));

    logic stamp_mode, check_mode;
    assign stamp_mode = (op_reg == OP_STAMP) || (op_reg == OP_MOVE);
    assign check_mode = (op_reg == OP_CHECK);

    // cell store: one write, one registered read per cycle
    logic [OWNER_BITS-1:0] cell_mem [DEPTH];
    logic [OWNER_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [OWNER_BITS-1:0] mem_wdata;

    logic                  ers_pend_reg;
    logic [ADDR_W-1:0]     ers_addr_reg;
    logic                  chk_pend_reg;
    logic                  chk_oob_reg;
    logic                  ers_hit;

    assign ers_hit = ers_pend_reg && (rdata_reg == owner_reg);

    always_comb
    begin
        mem_we    = cmd.clr_go || ers_hit || (cmd.rect_go && stamp_mode && in_grid);
        mem_wdata = cmd.rect_go ? owner_reg : '0;
        if (cmd.clr_go)
        begin
            mem_waddr = lin_reg;
        end
        else if (ers_pend_reg)
        begin
            mem_waddr = ers_addr_reg;
        end
        else
        begin
            mem_waddr = rect_addr;
        end
        mem_raddr = cmd.ers_go ? lin_reg : rect_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= cell_mem[mem_raddr];
    end

    // compare stage, in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ers_pend_reg <= 1'b0;
            chk_pend_reg <= 1'b0;
        end
        else
        begin
            ers_pend_reg <= cmd.ers_go;
            chk_pend_reg <= cmd.rect_go && check_mode;
        end
    end

    logic blocked_reg;

    always_ff @(posedge clk)
    begin
        ers_addr_reg <= lin_reg;
        chk_oob_reg  <= !in_grid;
        if (cmd.accept)
        begin
            blocked_reg <= 1'b0;
        end
        else if (chk_pend_reg &&
                 (chk_oob_reg || (rdata_reg != '0 && rdata_reg != owner_reg)))
        begin
            blocked_reg <= 1'b1;
        end
    end

    // result register
    logic res_valid_reg, res_valid_next;
    logic res_blocked_reg;
    op_t  res_op_reg;
    logic res_free;

    assign res_free = !res_valid_reg || rsp_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.post)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            res_blocked_reg <= blocked_reg;
            res_op_reg      <= op_reg;
        end
    end

    assign rsp_valid          = res_valid_reg;
    assign rsp_blocked        = res_blocked_reg;
    assign rsp_done_operation = res_op_reg;

    assign sts.op         = op_reg;
    assign sts.lin_last   = lin_last;
    assign sts.rect_last  = rect_last;
    assign sts.rect_empty = rect_empty;
    assign sts.res_free   = res_free;

endmodule

[src/owner_grid_collision_map_top.sv]
`timescale 1ns / 1ps
// Stamp and check walk the clamped w*h rectangle one cell at a time; clear and erase sweep
//   every cell of the store, and move runs the erase sweep and then the stamp walk.
// One cell per cycle through the single-port-write, registered-read cell store; one request
//   is worked at a time, the next is taken only after the result is registered.
// Reset: grid size returns to 128 x 64, then a clearing pass over all MAX_ROWS*MAX_COLUMNS
//   cells (8192 by default) writes every cell free while the request channel is not ready.
module owner_grid_collision_map_top #(
    parameter int MAX_COLUMNS   = ogcm_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = ogcm_pkg::DEF_MAX_ROWS,
    parameter int MAX_RECT_SIDE = ogcm_pkg::DEF_MAX_RECT_SIDE,
    parameter int OWNER_BITS    = ogcm_pkg::DEF_OWNER_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ogcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ogcm_pkg::CFG_DATA_W-1:0] cfg_data,
    ogcm_req_if.sink                        req,
    ogcm_rsp_if.source                      rsp
);
    import ogcm_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic ctl_ready;

    assign req.ready = ctl_ready;

    ogcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctl_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ogcm_dp #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .MAX_RECT_SIDE (MAX_RECT_SIDE),
        .OWNER_BITS    (OWNER_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .req_operation      (req.operation),
        .req_x_origin       (req.x_origin),
        .req_y_origin       (req.y_origin),
        .req_rect_width     (req.rect_width),
        .req_rect_height    (req.rect_height),
        .req_owner_id       (req.owner_id),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .rsp_blocked        (rsp.blocked),
        .rsp_done_operation (rsp.done_operation),
        .cmd                (cmd),
        .sts                (sts)
    );

endmodule

[src/ogcm_checker.sv]
`timescale 1ns / 1ps
module ogcm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic [ogcm_pkg::OP_W-1:0]   req_operation,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_blocked,
    input logic [ogcm_pkg::OP_W-1:0]   rsp_done_operation
);
    import ogcm_pkg::*;

    logic       req_fire, rsp_fire;
    logic [1:0] pend_reg;
    op_t        last_op_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            last_op_reg <= OP_CLEAR;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(req_fire) - 2'(rsp_fire);
            if (req_fire)
            begin
                last_op_reg <= req_operation;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blocked)
                                    && $stable(rsp_done_operation))
        else $error("response word changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> pend_reg <= 2'd1)
        else $error("request accepted with two words outstanding");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without outstanding request");

    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && pend_reg == 2'd1 |-> rsp_done_operation == last_op_reg)
        else $error("echoed operation does not match request");

    a_blocked_check_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_done_operation != OP_CHECK |-> !rsp_blocked)
        else $error("blocked set on a non-check operation");

endmodule

bind owner_grid_collision_map_top ogcm_checker u_ogcm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_operation      (req.operation),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_blocked        (rsp.blocked),
    .rsp_done_operation (rsp.done_operation)
);

[tb/sv/ogcm_map_checker.sv]
`timescale 1ns / 1ps
module ogcm_map_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  ogcm_pkg::cfg_idx_t              cfg_index,
    input  logic [ogcm_pkg::CFG_DATA_W-1:0] cfg_data,
    ogcm_req_if                             req,
    ogcm_rsp_if                             rsp,
    output int                              mismatch_count,
    output int                              awaited_count
);
    import ogcm_pkg::*;

    localparam int COLS     = DEF_MAX_COLUMNS;
    localparam int ROWS     = DEF_MAX_ROWS;
    localparam int SIDE_MAX = DEF_MAX_RECT_SIDE;
    localparam int OWN_W    = DEF_OWNER_BITS;

    typedef struct packed {
        logic blocked;
        op_t  done_op;
    } reply_t;

    logic [OWN_W-1:0]    occupancy [COLS*ROWS];
    logic [GRID_W_W-1:0] grid_cols;
    logic [GRID_H_W-1:0] grid_rows;
    reply_t              awaited_replies [$];

    function automatic int cols_used();
        return (grid_cols > COLS) ? COLS : int'(grid_cols);
    endfunction

    function automatic int rows_used();
        return (grid_rows > ROWS) ? ROWS : int'(grid_rows);
    endfunction

    function automatic int clamp_side(logic [SIDE_IN_W-1:0] s);
        return (s > SIDE_MAX) ? SIDE_MAX : int'(s);
    endfunction

    function automatic void erase_cells(logic [OWN_W-1:0] own);
        for (int k = 0; k < COLS*ROWS; k++)
        begin
            if (occupancy[k] == own)
                occupancy[k] = '0;
        end
    endfunction

    // stamp is clipped to the grid in use
    function automatic void stamp_cells(int x0, int y0, int w, int h, logic [OWN_W-1:0] own);
        int cw;
        int ch;
        int x;
        int y;
        cw = cols_used();
        ch = rows_used();
        for (int i = 0; i < h; i++)
        begin
            for (int j = 0; j < w; j++)
            begin
                x = x0 + j;
                y = y0 + i;
                if (x >= 0 && x < cw && y >= 0 && y < ch)
                    occupancy[y*COLS + x] = own;
            end
        end
    endfunction

    // any cell off the grid, or held by someone else, blocks
    function automatic logic rect_blocked(int x0, int y0, int w, int h, logic [OWN_W-1:0] own);
        int cw;
        int ch;
        int x;
        int y;
        logic [OWN_W-1:0] held;
        cw = cols_used();
        ch = rows_used();
        for (int i = 0; i < h; i++)
        begin
            for (int j = 0; j < w; j++)
            begin
                x = x0 + j;
                y = y0 + i;
                if (x < 0 || x >= cw || y < 0 || y >= ch)
                    return 1'b1;
                held = occupancy[y*COLS + x];
                if (held != '0 && held != own)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic reply_t apply_request(op_t op, int x0, int y0, int w, int h,
                                             logic [OWN_W-1:0] own);
        reply_t r;
        r.blocked = 1'b0;
        r.done_op = op;
        case (op)
            OP_CLEAR:
            begin
                for (int k = 0; k < COLS*ROWS; k++)
                    occupancy[k] = '0;
            end
            OP_STAMP: stamp_cells(x0, y0, w, h, own);
            OP_ERASE: erase_cells(own);
            OP_CHECK: r.blocked = rect_blocked(x0, y0, w, h, own);
            OP_MOVE:
            begin
                erase_cells(own);
                stamp_cells(x0, y0, w, h, own);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < COLS*ROWS; k++)
                occupancy[k] = '0;
            grid_cols = GRID_WIDTH_RST;
            grid_rows = GRID_HEIGHT_RST;
            awaited_replies.delete();
            awaited_count = 0;
        end
        else
        begin : sample
            reply_t got;
            reply_t want;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  grid_cols = cfg_data[GRID_W_W-1:0];
                    CFG_GRID_HEIGHT: grid_rows = cfg_data[GRID_H_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                got.blocked = rsp.blocked;
                got.done_op = rsp.done_operation;
                if (awaited_replies.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result word with none pending: blocked=%0b op=%0d",
                                 $time, got.blocked, got.done_op);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (want !== got)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: mismatch: blocked exp %0b got %0b, op exp %0d got %0d",
                                     $time, want.blocked, got.blocked, want.done_op, got.done_op);
                        mismatch_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                awaited_replies.push_back(apply_request(req.operation,
                                                        int'($signed(req.x_origin)),
                                                        int'($signed(req.y_origin)),
                                                        clamp_side(req.rect_width),
                                                        clamp_side(req.rect_height),
                                                        req.owner_id[OWN_W-1:0]));
            awaited_count = awaited_replies.size();
        end
    end

endmodule

[tb/sv/owner_grid_collision_map_top_tb.sv]
`timescale 1ns / 1ps
module owner_grid_collision_map_top_tb;
    import ogcm_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatch_count;
    int awaited_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cur_cols;
    int cur_rows;
    logic [OWNER_IN_W-1:0] owner_pool [4];

    ogcm_req_if req_ch ();
    ogcm_rsp_if rsp_ch ();

    owner_grid_collision_map_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    ogcm_map_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #150_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial rsp_ch.ready = 1'b0;

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_req(op_t op, int x, int y, int w, int h, int own);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.x_origin    <= x[COORD_IN_W-1:0];
        req_ch.y_origin    <= y[COORD_IN_W-1:0];
        req_ch.rect_width  <= w[SIDE_IN_W-1:0];
        req_ch.rect_height <= h[SIDE_IN_W-1:0];
        req_ch.owner_id    <= own[OWNER_IN_W-1:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_grid(int cols, int rows);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data  <= cols[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data  <= rows[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_cols = (cols > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols;
        cur_rows = (rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows;
    endtask

    // mostly small rectangles near the grid with a few recurring owners
    task automatic send_random();
        int  r;
        op_t op;
        int  own;
        int  x;
        int  y;
        int  w;
        int  h;
        r = $urandom_range(0, 99);
        if (r < 28)
            op = OP_STAMP;
        else if (r < 60)
            op = OP_CHECK;
        else if (r < 72)
            op = OP_MOVE;
        else if (r < 80)
            op = OP_ERASE;
        else if (r < 84)
            op = OP_CLEAR;
        else if (r < 90)
            op = op_t'($urandom_range(OP_MOVE + 1, (1 << OP_W) - 1));
        else
            op = OP_CHECK;

        if (r >= 90 || $urandom_range(0, 99) < 15)
        begin
            x = $urandom_range(0, 511);
            y = $urandom_range(0, 511);
        end
        else
        begin
            x = $urandom_range(0, cur_cols + 7) - 4;
            y = $urandom_range(0, cur_rows + 7) - 4;
        end

        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
        end
        else if (r < 90)
        begin
            w = $urandom_range(0, 64);
            h = $urandom_range(0, 64);
        end
        else
        begin
            w = $urandom_range(0, 127);
            h = $urandom_range(0, 127);
        end

        r = $urandom_range(0, 99);
        if (r < 85)
            own = int'(owner_pool[$urandom_range(0, 3)]);
        else if (r < 90)
            own = 0;
        else
            own = $urandom_range(0, 255);

        send_req(op, x, y, w, h, own);
    endtask

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_CLEAR;
        req_ch.x_origin    = '0;
        req_ch.y_origin    = '0;
        req_ch.rect_width  = '0;
        req_ch.rect_height = '0;
        req_ch.owner_id    = '0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_GRID_WIDTH;
        cfg_data           = '0;
        rst_n              = 1'b0;
        cur_cols           = DEF_MAX_COLUMNS;
        cur_rows           = DEF_MAX_ROWS;
        for (int i = 0; i < 4; i++)
            owner_pool[i] = OWNER_IN_W'($urandom_range(1, 255));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // store is swept clear after reset; request side stays low until done
        while (!req_ch.ready)
            @(negedge clk);

        send_req(OP_CHECK, 0, 0, 64, 64, 1);
        send_req(OP_STAMP, -256, -256, 64, 64, 1);        // fully off grid
        send_req(OP_STAMP, 120, 60, 64, 64, 255);         // clipped at the corner
        send_req(OP_CHECK, 120, 60, 8, 4, 255);
        send_req(OP_CHECK, 120, 60, 9, 4, 255);           // one column past the edge
        send_req(OP_CHECK, 100, 50, 30, 20, 7);
        send_req(OP_STAMP, 0, 0, 0, 5, 3);                // empty rectangle
        send_req(OP_CHECK, -256, -256, 0, 0, 3);          // empty, never blocked
        send_req(OP_STAMP, 10, 10, 127, 1, 9);            // side saturates
        send_req(OP_CHECK, 73, 10, 1, 1, 8);
        send_req(OP_CHECK, 74, 10, 1, 1, 8);
        send_req(OP_CHECK, 0, 10, 20, 1, 0);              // owner zero sees any holder
        send_req(OP_STAMP, 120, 60, 4, 4, 0);             // owner zero frees cells
        send_req(OP_ERASE, 0, 0, 1, 1, 0);
        send_req(OP_ERASE, 0, 0, 1, 1, 255);
        send_req(OP_MOVE, 255, 255, 1, 1, 9);
        send_req(OP_CHECK, 10, 10, 64, 1, 5);
        send_req(OP_MOVE, 0, 0, 2, 2, 9);
        send_req(OP_CHECK, -1, 0, 2, 2, 9);
        for (int c = OP_MOVE + 1; c < (1 << OP_W); c++)
            send_req(op_t'(c), $urandom_range(0, 511), $urandom_range(0, 511),
                     $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 255));
        send_req(OP_CLEAR, 255, -1, 127, 127, 255);
        send_req(OP_CHECK, 0, 0, 64, 64, 200);

        // grid size changes keep the stored cells, so later phases see stale owners
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_grid(255, 127);
                1: set_grid(1, 1);
                2: set_grid(0, $urandom_range(1, 64));
                3: set_grid(DEF_MAX_COLUMNS, DEF_MAX_ROWS);
                4: set_grid($urandom_range(1, 128), 0);
                default: set_grid($urandom_range(1, 128), $urandom_range(1, 64));
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default:
                begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            repeat (15) send_random();
        end

        wait_drained();
        repeat (64) @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
